// ===== sv/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared constants and types for the closed Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package ccr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MAX_POINTS = 64;
   localparam int MIN_POINTS = 4;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int QW         = 32 - FRAC_BITS;

   // parameter wrap: restoring modulo over a few stages
   localparam int MOD_STAGES = 4;
   localparam int MOD_STEP   = (QW + MOD_STAGES - 1) / MOD_STAGES;
   localparam int MW         = MOD_STAGES * MOD_STEP;

   // Horner datapath widths
   localparam int CW = 38;
   localparam int PW = CW + FRAC_BITS + 1;

   // pipeline stage numbering
   localparam int ST_FX  = MOD_STAGES;
   localparam int ST_RD  = ST_FX + 1;
   localparam int ST_CF  = ST_RD + 1;
   localparam int ST_M1  = ST_CF + 1;
   localparam int ST_A1  = ST_M1 + 1;
   localparam int ST_M2  = ST_A1 + 1;
   localparam int ST_A2  = ST_M2 + 1;
   localparam int ST_M3  = ST_A2 + 1;
   localparam int ST_A3  = ST_M3 + 1;
   localparam int ST_OUT = ST_A3 + 1;
   localparam int NS     = ST_OUT + 1;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_EVAL   = 2'd2;

   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

   typedef logic signed [CW-1:0] coef_type;
   typedef logic signed [PW-1:0] prod_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef struct packed {
      logic [IDX_W-1:0]     i0;
      logic [IDX_W-1:0]     i1;
      logic [IDX_W-1:0]     i2;
      logic [IDX_W-1:0]     i3;
      logic [FRAC_BITS-1:0] t;
      logic                 enough;
   } seg_type;

endpackage

// ===== sv/ccr_wrap.sv =====
// ----------------------------------------------------------------------------
// ccr_wrap
// Wraps the curve parameter modulo the point count and forms the four
// neighbor indices and the local t.
// ----------------------------------------------------------------------------
module ccr_wrap (
   input  logic                     clock,
   input  logic [ccr_pkg::ST_FX:0]  en,
   input  logic signed [31:0]       param,
   input  logic [ccr_pkg::CNT_W-1:0] count,
   output ccr_pkg::seg_type         seg
);
   import ccr_pkg::*;

   function automatic logic [CNT_W-1:0] mod_step_f(input logic [CNT_W-1:0] rem_i,
                                                   input logic [MOD_STEP-1:0] bits_i,
                                                   input logic [CNT_W-1:0] n_i);
      logic [CNT_W:0] acc;
      acc = {1'b0, rem_i};
      for (int k = MOD_STEP - 1; k >= 0; k--) begin
         acc = {acc[CNT_W-1:0], bits_i[k]};
         if (acc >= {1'b0, n_i}) begin
            acc = acc - {1'b0, n_i};
         end
      end
      return acc[CNT_W-1:0];
   endfunction

   logic [CNT_W-1:0]     rem_ff [MOD_STAGES];
   logic [MW-1:0]        mag_ff [MOD_STAGES];
   logic                 neg_ff [MOD_STAGES];
   logic [CNT_W-1:0]     n_ff   [MOD_STAGES];
   logic [FRAC_BITS-1:0] t_ff   [MOD_STAGES];

   logic [QW-1:0] q;
   logic [QW-1:0] q_mag;
   logic [MW-1:0] mag0;

   assign q     = param[31:FRAC_BITS];
   assign q_mag = q[QW-1] ? (~q + 1'b1) : q;
   assign mag0  = MW'(q_mag);

   for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
      logic [CNT_W-1:0]     rem_src;
      logic [MW-1:0]        mag_src;
      logic                 neg_src;
      logic [CNT_W-1:0]     n_src;
      logic [FRAC_BITS-1:0] t_src;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign mag_src = mag0;
         assign neg_src = q[QW-1];
         assign n_src   = count;
         assign t_src   = param[FRAC_BITS-1:0];
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign mag_src = mag_ff[s-1];
         assign neg_src = neg_ff[s-1];
         assign n_src   = n_ff[s-1];
         assign t_src   = t_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s] <= mod_step_f(rem_src, mag_src[MW-1-s*MOD_STEP -: MOD_STEP], n_src);
            mag_ff[s] <= mag_src;
            neg_ff[s] <= neg_src;
            n_ff[s]   <= n_src;
            t_ff[s]   <= t_src;
         end
      end
   end

   // floor-mod fix-up and cyclic neighbors
   logic [CNT_W-1:0] m, n, r, r1, r2, i0, i2, i3;
   seg_type          seg_in, seg_ff;

   always_comb begin
      m  = rem_ff[MOD_STAGES-1];
      n  = n_ff[MOD_STAGES-1];
      r  = (neg_ff[MOD_STAGES-1] && (m != '0)) ? (n - m) : m;
      r1 = r + 1'b1;
      r2 = r + 2'd2;
      i0 = (r == '0) ? (n - 1'b1) : (r - 1'b1);
      i2 = (r1 == n) ? '0 : r1;
      i3 = (r2 >= n) ? (r2 - n) : r2;
      seg_in.i0     = i0[IDX_W-1:0];
      seg_in.i1     = r[IDX_W-1:0];
      seg_in.i2     = i2[IDX_W-1:0];
      seg_in.i3     = i3[IDX_W-1:0];
      seg_in.t      = t_ff[MOD_STAGES-1];
      seg_in.enough = (n >= CNT_W'(MIN_POINTS));
   end

   always_ff @(posedge clock) begin
      if (en[ST_FX]) begin
         seg_ff <= seg_in;
      end
   end

   assign seg = seg_ff;

endmodule

// ===== sv/ccr_table.sv =====
// ----------------------------------------------------------------------------
// ccr_table
// Control point store. Two copies, each read at two addresses, give the four
// neighbors from one registered read.
// ----------------------------------------------------------------------------
module ccr_table (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ccr_pkg::IDX_W-1:0] wr_idx,
   input  ccr_pkg::point_type        wr_pt,
   input  logic                      rd_en,
   input  ccr_pkg::seg_type          seg,
   output ccr_pkg::point_type        p0,
   output ccr_pkg::point_type        p1,
   output ccr_pkg::point_type        p2,
   output ccr_pkg::point_type        p3
);
   import ccr_pkg::*;

   point_type mem_a [MAX_POINTS];
   point_type mem_b [MAX_POINTS];
   point_type p0_ff, p1_ff, p2_ff, p3_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_idx] <= wr_pt;
         mem_b[wr_idx] <= wr_pt;
      end
      if (rd_en) begin
         p0_ff <= mem_a[seg.i0];
         p1_ff <= mem_a[seg.i1];
         p2_ff <= mem_b[seg.i2];
         p3_ff <= mem_b[seg.i3];
      end
   end

   assign p0 = p0_ff;
   assign p1 = p1_ff;
   assign p2 = p2_ff;
   assign p3 = p3_ff;

endmodule

// ===== sv/ccr_axis.sv =====
// ----------------------------------------------------------------------------
// ccr_axis
// One coordinate: spline coefficients, Horner evaluation of point and
// derivative, rounding and saturation.
// ----------------------------------------------------------------------------
module ccr_axis (
   input  logic                          clock,
   input  logic [ccr_pkg::NS-1:0]        en,
   input  logic signed [31:0]            p0,
   input  logic signed [31:0]            p1,
   input  logic signed [31:0]            p2,
   input  logic signed [31:0]            p3,
   input  logic [ccr_pkg::FRAC_BITS-1:0] t,
   input  logic                          ok,
   input  logic signed [31:0]            fb_slope,
   output logic signed [31:0]            pos,
   output logic signed [31:0]            slope,
   output logic                          ok_out
);
   import ccr_pkg::*;

   localparam coef_type SAT_HI = coef_type'({1'b0, {31{1'b1}}});
   localparam coef_type SAT_LO = ~SAT_HI;

   function automatic coef_type rnd_f(input prod_type x);
      prod_type y;
      y = x + (prod_type'(1) <<< (FRAC_BITS - 1));
      return coef_type'(y >>> FRAC_BITS);
   endfunction

   function automatic logic signed [31:0] fin_f(input coef_type v);
      coef_type h;
      h = (v + coef_type'(1)) >>> 1;
      if (h > SAT_HI) begin
         h = SAT_HI;
      end else if (h < SAT_LO) begin
         h = SAT_LO;
      end
      return h[31:0];
   endfunction

   coef_type e0, e1, e2, e3;
   assign e0 = coef_type'(p0);
   assign e1 = coef_type'(p1);
   assign e2 = coef_type'(p2);
   assign e3 = coef_type'(p3);

   // coefficients
   coef_type cf_a_ff, cf_b_ff, cf_c_ff, cf_c2_ff, cf_d_ff, cf_d3_ff;
   logic [FRAC_BITS-1:0] cf_t_ff;
   logic                 cf_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_CF]) begin
         cf_a_ff  <= e1 <<< 1;
         cf_b_ff  <= e2 - e0;
         cf_c_ff  <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
         cf_c2_ff <= (e0 <<< 2) - ((e1 <<< 3) + (e1 <<< 1)) + (e2 <<< 3) - (e3 <<< 1);
         cf_d_ff  <= ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
         cf_d3_ff <= ((e1 <<< 3) + e1) - ((e2 <<< 3) + e2) + ((e3 <<< 1) + e3)
                     - ((e0 <<< 1) + e0);
         cf_t_ff  <= t;
         cf_ok_ff <= ok;
      end
   end

   logic signed [FRAC_BITS:0] cf_ts, a1_ts, a2_ts;
   assign cf_ts = {1'b0, cf_t_ff};

   // multiply 1
   prod_type m1_pp_ff, m1_ps_ff;
   coef_type m1_a_ff, m1_b_ff, m1_c_ff, m1_c2_ff;
   logic [FRAC_BITS-1:0] m1_t_ff;
   logic                 m1_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_M1]) begin
         m1_pp_ff <= cf_d_ff * cf_ts;
         m1_ps_ff <= cf_d3_ff * cf_ts;
         m1_a_ff  <= cf_a_ff;
         m1_b_ff  <= cf_b_ff;
         m1_c_ff  <= cf_c_ff;
         m1_c2_ff <= cf_c2_ff;
         m1_t_ff  <= cf_t_ff;
         m1_ok_ff <= cf_ok_ff;
      end
   end

   // add 1
   coef_type a1_p_ff, a1_s_ff, a1_a_ff, a1_b_ff;
   logic [FRAC_BITS-1:0] a1_t_ff;
   logic                 a1_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_A1]) begin
         a1_p_ff  <= rnd_f(m1_pp_ff) + m1_c_ff;
         a1_s_ff  <= rnd_f(m1_ps_ff) + m1_c2_ff;
         a1_a_ff  <= m1_a_ff;
         a1_b_ff  <= m1_b_ff;
         a1_t_ff  <= m1_t_ff;
         a1_ok_ff <= m1_ok_ff;
      end
   end
   assign a1_ts = {1'b0, a1_t_ff};

   // multiply 2
   prod_type m2_pp_ff, m2_ps_ff;
   coef_type m2_a_ff, m2_b_ff;
   logic [FRAC_BITS-1:0] m2_t_ff;
   logic                 m2_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_M2]) begin
         m2_pp_ff <= a1_p_ff * a1_ts;
         m2_ps_ff <= a1_s_ff * a1_ts;
         m2_a_ff  <= a1_a_ff;
         m2_b_ff  <= a1_b_ff;
         m2_t_ff  <= a1_t_ff;
         m2_ok_ff <= a1_ok_ff;
      end
   end

   // add 2: slope done here
   coef_type a2_p_ff, a2_s_ff, a2_a_ff;
   logic [FRAC_BITS-1:0] a2_t_ff;
   logic                 a2_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_A2]) begin
         a2_p_ff  <= rnd_f(m2_pp_ff) + m2_b_ff;
         a2_s_ff  <= rnd_f(m2_ps_ff) + m2_b_ff;
         a2_a_ff  <= m2_a_ff;
         a2_t_ff  <= m2_t_ff;
         a2_ok_ff <= m2_ok_ff;
      end
   end
   assign a2_ts = {1'b0, a2_t_ff};

   // multiply 3
   prod_type m3_pp_ff;
   coef_type m3_s_ff, m3_a_ff;
   logic     m3_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_M3]) begin
         m3_pp_ff <= a2_p_ff * a2_ts;
         m3_s_ff  <= a2_s_ff;
         m3_a_ff  <= a2_a_ff;
         m3_ok_ff <= a2_ok_ff;
      end
   end

   // add 3
   coef_type a3_p_ff, a3_s_ff;
   logic     a3_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_A3]) begin
         a3_p_ff  <= rnd_f(m3_pp_ff) + m3_a_ff;
         a3_s_ff  <= m3_s_ff;
         a3_ok_ff <= m3_ok_ff;
      end
   end

   // round, saturate, fallback
   logic signed [31:0] pos_ff, slope_ff;
   logic               ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         pos_ff   <= a3_ok_ff ? fin_f(a3_p_ff) : '0;
         slope_ff <= a3_ok_ff ? fin_f(a3_s_ff) : fb_slope;
         ok_ff    <= a3_ok_ff;
      end
   end

   assign pos    = pos_ff;
   assign slope  = slope_ff;
   assign ok_out = ok_ff;

endmodule

// ===== sv/closed_catmull_rom_eval_core.sv =====
// ----------------------------------------------------------------------------
// closed_catmull_rom_eval_core
// Closed-loop uniform Catmull-Rom spline: point table plus a pipelined
// evaluator of curve point and derivative.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// req      in         req_valid / req_ready   kind, point_x/y/z, curve_param
// rsp      out        rsp_valid / rsp_ready   pos_x/y/z, slope_x/y/z, enough_points
//
// Evaluate requests stream at one per cycle unless rsp stalls (four modulo
// stages, index fix-up, table read, seven coefficient/Horner stages, output).
// Clear and append take effect in the cycle they are accepted.
// An append waits while an evaluate is still ahead of the table read.
// Synchronous reset empties the table and the pipeline; no clearing pass.
// A stall on rsp closes bubbles first and then holds each stage in place.
// ----------------------------------------------------------------------------
module closed_catmull_rom_eval_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_curve_param,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_slope_x,
   output logic signed [31:0] rsp_slope_y,
   output logic signed [31:0] rsp_slope_z,
   output logic               rsp_enough_points
);
   import ccr_pkg::*;

   logic [NS-1:0]    valid_ff, valid_in, en;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy, is_eval, is_app, accept, wr_en;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign busy      = |valid_ff[ST_FX:0];
   assign is_eval   = (req_kind == KIND_EVAL);
   assign is_app    = (req_kind == KIND_APPEND);
   assign req_ready = is_eval ? en[0] : !(is_app && busy);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && is_app && (count_ff < CNT_W'(MAX_POINTS));

   always_comb begin
      valid_in    = {valid_ff[NS-2:0], 1'b0};
      valid_in[0] = accept && is_eval;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (req_kind)
            KIND_CLEAR:  count_in = '0;
            KIND_APPEND: count_in = wr_en ? (count_ff + 1'b1) : count_ff;
            default:     count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
         count_ff <= count_in;
      end
   end

   seg_type   seg;
   point_type wr_pt, p0, p1, p2, p3;

   assign wr_pt.x = req_point_x;
   assign wr_pt.y = req_point_y;
   assign wr_pt.z = req_point_z;

   ccr_wrap u_wrap (
      .clock (clock),
      .en    (en[ST_FX:0]),
      .param (req_curve_param),
      .count (count_ff),
      .seg   (seg)
   );

   ccr_table u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_idx (count_ff[IDX_W-1:0]),
      .wr_pt  (wr_pt),
      .rd_en  (en[ST_RD]),
      .seg    (seg),
      .p0     (p0),
      .p1     (p1),
      .p2     (p2),
      .p3     (p3)
   );

   logic [FRAC_BITS-1:0] rd_t_ff;
   logic                 rd_ok_ff;

   always_ff @(posedge clock) begin
      if (en[ST_RD]) begin
         rd_t_ff  <= seg.t;
         rd_ok_ff <= seg.enough;
      end
   end

   ccr_axis u_axis_x (
      .clock (clock), .en (en),
      .p0 (p0.x), .p1 (p1.x), .p2 (p2.x), .p3 (p3.x),
      .t (rd_t_ff), .ok (rd_ok_ff), .fb_slope (ONE_Q),
      .pos (rsp_pos_x), .slope (rsp_slope_x), .ok_out (rsp_enough_points)
   );

   ccr_axis u_axis_y (
      .clock (clock), .en (en),
      .p0 (p0.y), .p1 (p1.y), .p2 (p2.y), .p3 (p3.y),
      .t (rd_t_ff), .ok (rd_ok_ff), .fb_slope (32'sd0),
      .pos (rsp_pos_y), .slope (rsp_slope_y), .ok_out ()
   );

   ccr_axis u_axis_z (
      .clock (clock), .en (en),
      .p0 (p0.z), .p1 (p1.z), .p2 (p2.z), .p3 (p3.z),
      .t (rd_t_ff), .ok (rd_ok_ff), .fb_slope (32'sd0),
      .pos (rsp_pos_z), .slope (rsp_slope_z), .ok_out ()
   );

   assign rsp_valid = valid_ff[NS-1];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond table size");

   a_no_write_under_read: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy)
      else $error("table write while an evaluate is ahead of the read");

   a_fallback: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_enough_points) |->
         (rsp_pos_x == 32'sd0 && rsp_slope_x == ONE_Q && rsp_slope_y == 32'sd0))
      else $error("fallback result malformed");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)))
      else $error("stalled result lost");

endmodule
